>>> rtl/core/assert_macros.svh
// Assertion helpers used by pffl_ctrl. All checks sample on the rising edge of
// clock and are switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PFFL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define PFFL_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pffl_pkg.sv
package pffl_pkg;

   // Fixed geometry of a page frame and of the request and result fields.
   localparam int FRAME_BYTES   = 4096;
   localparam int FRAME_SHIFT   = 12;
   localparam int ADDR_BITS     = 32;
   localparam int SIZE_BITS     = 23;
   localparam int COUNT_BITS    = 11;
   localparam int PAGE_IDX_BITS = ADDR_BITS - FRAME_SHIFT;
   localparam int CSR_IDX_BITS  = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAP_BASE = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAP_SIZE = 4'd1;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_INIT  = 2'd2,
      MODE_FINAL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_EMPTY       = 3'd1,
      STAT_MISALIGNED  = 3'd2,
      STAT_NOT_INIT    = 3'd3,
      STAT_ALREADY     = 3'd4,
      STAT_OUTSIDE     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_ALLOC,
      CS_INIT
   } ctrl_state_type;

   typedef struct packed {
      mode_type               mode;
      logic [ADDR_BITS-1:0]   free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   frame_address;
      status_type             status;
      logic [COUNT_BITS-1:0]  remaining_frames;
      logic [COUNT_BITS-1:0]  total_frames;
   } rsp_type;

   // Live configuration handed from the register file to the controller.
   typedef struct packed {
      logic [ADDR_BITS-1:0]   heap_base;
      logic [SIZE_BITS-1:0]   heap_size;
   } cfg_type;

endpackage

>>> rtl/core/pffl_table.sv
module pffl_table
   #(
      parameter int DEPTH  = 1024,
      parameter int DATA_W = 11
   )
   (
      input  logic                       clock,
      input  logic                       wr_en,
      input  logic [$clog2(DEPTH)-1:0]   wr_addr,
      input  logic [DATA_W-1:0]          wr_data,
      input  logic                       rd_en,
      input  logic [$clog2(DEPTH)-1:0]   rd_addr,
      output logic [DATA_W-1:0]          rd_data
   );

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pffl_ctrl.sv
module pffl_ctrl
   import pffl_pkg::*;
   #(
      parameter int MAX_FRAMES = 1024
   )
   (
      input  logic                           clock,
      input  logic                           reset,
      input  cfg_type                        cfg,
      input  logic                           start,
      output logic                           busy,
      input  req_type                        req_data,
      output logic                           rsp_strobe,
      output rsp_type                        rsp_data,
      output logic                           tbl_wr_en,
      output logic [$clog2(MAX_FRAMES)-1:0]  tbl_wr_addr,
      output logic [$clog2(MAX_FRAMES+1)-1:0] tbl_wr_data,
      output logic                           tbl_rd_en,
      output logic [$clog2(MAX_FRAMES)-1:0]  tbl_rd_addr,
      input  logic [$clog2(MAX_FRAMES+1)-1:0] tbl_rd_data
   );

   localparam int ADDR_W = $clog2(MAX_FRAMES);
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam logic [CNT_W-1:0] SENTINEL = CNT_W'(MAX_FRAMES);

   ctrl_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       free_count_ff, free_count_in;
   logic [CNT_W-1:0]       frame_total_ff, frame_total_in;
   logic                   init_ff, init_in;
   logic [ADDR_W-1:0]      init_idx_ff, init_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   head_empty;
   logic [ADDR_BITS-1:0]   alloc_addr;
   logic                   free_misaligned;
   logic                   free_outside;
   logic [ADDR_BITS-1:0]   free_diff;
   logic [PAGE_IDX_BITS-1:0] free_idx;
   logic [COUNT_BITS-1:0]  size_frames;
   logic [CNT_W-1:0]       init_n;
   logic                   init_last;

   assign accept = start && (state_ff == CS_IDLE);
   assign busy   = (state_ff != CS_IDLE);

   // Head of the list and the address it stands for.
   assign head_empty = 32'(head_ff) >= 32'(MAX_FRAMES);
   assign alloc_addr = cfg.heap_base
                     + (32'(head_ff[ADDR_W-1:0]) << FRAME_SHIFT);

   // Alignment and range checks of a returned frame.
   assign free_diff       = req_data.free_address - cfg.heap_base;
   assign free_idx        = free_diff[ADDR_BITS-1:FRAME_SHIFT];
   assign free_misaligned = (req_data.free_address[FRAME_SHIFT-1:0] != '0);
   assign free_outside    = (req_data.free_address < cfg.heap_base)
                         || (free_diff[FRAME_SHIFT-1:0] != '0)
                         || (32'(free_idx) >= 32'(frame_total_ff));

   // Frame count of the heap, capped at the table depth.
   assign size_frames = cfg.heap_size[SIZE_BITS-1:FRAME_SHIFT];
   assign init_n = (32'(size_frames) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                         : CNT_W'(size_frames);
   assign init_last = (32'(init_idx_ff) + 32'd1) >= 32'(frame_total_ff);

   // Next state, register updates and table accesses.
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      free_count_in  = free_count_ff;
      frame_total_in = frame_total_ff;
      init_in        = init_ff;
      init_idx_in    = init_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      tbl_wr_en      = 1'b0;
      tbl_wr_addr    = free_idx[ADDR_W-1:0];
      tbl_wr_data    = head_ff;
      tbl_rd_en      = 1'b0;
      tbl_rd_addr    = head_ff[ADDR_W-1:0];

      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               rsp_in.frame_address = '0;
               rsp_in.status        = STAT_OK;
               rsp_valid_in         = 1'b1;
               if (req_data.mode == MODE_INIT) begin
                  if (init_ff) begin
                     rsp_in.status = STAT_ALREADY;
                  end else begin
                     frame_total_in = init_n;
                     free_count_in  = init_n;
                     init_in        = 1'b1;
                     init_idx_in    = '0;
                     if (init_n != '0) begin
                        // Chain the frames before answering.
                        head_in      = '0;
                        state_in     = CS_INIT;
                        rsp_valid_in = 1'b0;
                     end else begin
                        head_in = SENTINEL;
                     end
                  end
               end else if (!init_ff) begin
                  rsp_in.status = STAT_NOT_INIT;
               end else begin
                  case (req_data.mode)
                     MODE_FINAL: begin
                        free_count_in  = '0;
                        frame_total_in = '0;
                        head_in        = SENTINEL;
                        init_in        = 1'b0;
                     end
                     MODE_ALLOC: begin
                        if (head_empty) begin
                           rsp_in.status = STAT_EMPTY;
                        end else begin
                           // Fetch the successor of the head frame.
                           tbl_rd_en    = 1'b1;
                           state_in     = CS_ALLOC;
                           rsp_valid_in = 1'b0;
                        end
                     end
                     MODE_FREE: begin
                        if (free_misaligned) begin
                           rsp_in.status = STAT_MISALIGNED;
                        end else if (free_outside) begin
                           rsp_in.status = STAT_OUTSIDE;
                        end else begin
                           tbl_wr_en = 1'b1;
                           head_in   = CNT_W'(free_idx);
                           if (32'(free_count_ff) < 32'(MAX_FRAMES)) begin
                              free_count_in = free_count_ff + CNT_W'(1);
                           end
                        end
                     end
                     default: begin
                        rsp_in.status = STAT_OK;
                     end
                  endcase
               end
            end
         end
         CS_ALLOC: begin
            // The successor is back from the table: pop the head.
            head_in = tbl_rd_data;
            if (free_count_ff != '0) begin
               free_count_in = free_count_ff - CNT_W'(1);
            end
            rsp_in.frame_address = alloc_addr;
            rsp_in.status        = STAT_OK;
            rsp_valid_in         = 1'b1;
            state_in             = CS_IDLE;
         end
         CS_INIT: begin
            // Link one frame a cycle; the last one ends the list.
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = init_idx_ff;
            tbl_wr_data = init_last ? SENTINEL : (CNT_W'(init_idx_ff) + CNT_W'(1));
            if (init_last) begin
               rsp_in.frame_address = '0;
               rsp_in.status        = STAT_OK;
               rsp_valid_in         = 1'b1;
               state_in             = CS_IDLE;
            end else begin
               init_idx_in = init_idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase

      rsp_in.remaining_frames = COUNT_BITS'(free_count_in);
      rsp_in.total_frames     = COUNT_BITS'(frame_total_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= CS_IDLE;
         head_ff        <= SENTINEL;
         free_count_ff  <= '0;
         frame_total_ff <= '0;
         init_ff        <= 1'b0;
         init_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         free_count_ff  <= free_count_in;
         frame_total_ff <= frame_total_in;
         init_ff        <= init_in;
         init_idx_ff    <= init_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`include "assert_macros.svh"

   `PFFL_ASSERT_NEXT(a_alloc_one_wait, state_ff == CS_ALLOC, rsp_valid_ff && state_ff == CS_IDLE, "allocate did not answer after its table read")
   `PFFL_ASSERT(a_uninit_empty, !init_ff |-> (head_ff == SENTINEL && free_count_ff == '0), "list not empty while not initialized")
   `PFFL_ASSERT(a_write_source, tbl_wr_en |-> (state_ff == CS_INIT || (accept && req_data.mode == MODE_FREE)), "table written outside initialize or free")
   `PFFL_ASSERT(a_total_bound, 32'(frame_total_ff) <= 32'(MAX_FRAMES), "frame total above table depth")

endmodule

>>> rtl/core/page_frame_free_list_allocator.sv
// Page frame free-list allocator.
// Requests enter on req_data when start is high and busy is low. A request is
// allocate, free, initialize or finalize. Each request produces one result on
// rsp_data, shown for exactly one cycle while rsp_strobe is high; the receiver
// has no way to hold it off and must take it in that cycle.
// Free, finalize and any rejected request answer in the cycle after
// acceptance and a new request may follow right away. An allocate answers
// after the registered read of the next-frame table, since the head cannot
// move before it. An initialize of N frames answers once the write port of the
// table, one entry per cycle, has chained frames 0..N-1 (N of 0 answers at once).
// busy stays high while an allocate or an initialize is in progress.
// The configuration port (csr_*) is always ready; heap base is used live and
// heap size is sampled by initialize. Writes belong in idle periods.
// Reset empties the list, clears the counts and the initialized flag, and
// clears the configuration registers. The table contents are not cleared and
// stay undefined until an initialize or free writes them.
module page_frame_free_list_allocator
   import pffl_pkg::*;
   #(
      parameter int MAX_FRAMES = 1024
   )
   (
      input  logic                     clock,
      input  logic                     reset,
      input  logic                     start,
      output logic                     busy,
      input  req_type                  req_data,
      output logic                     rsp_strobe,
      output rsp_type                  rsp_data,
      input  logic                     csr_valid,
      output logic                     csr_ready,
      input  logic [CSR_IDX_BITS-1:0]  csr_index,
      input  logic [ADDR_BITS-1:0]     csr_data
   );

   localparam int ADDR_W = $clog2(MAX_FRAMES);
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

   cfg_type             cfg_ff, cfg_in;
   logic                tbl_wr_en;
   logic [ADDR_W-1:0]   tbl_wr_addr;
   logic [CNT_W-1:0]    tbl_wr_data;
   logic                tbl_rd_en;
   logic [ADDR_W-1:0]   tbl_rd_addr;
   logic [CNT_W-1:0]    tbl_rd_data;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HEAP_BASE: cfg_in.heap_base = csr_data;
            CSR_HEAP_SIZE: cfg_in.heap_size = csr_data[SIZE_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pffl_ctrl #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data)
   );

   pffl_table #(
      .DEPTH  (MAX_FRAMES),
      .DATA_W (CNT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

endmodule

>>> dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pffl_pkg::*;

   localparam int FRAME_LIMIT     = 1024;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int NUM_PHASES      = 8;
   localparam int CYCLE_LIMIT     = 10_000_000;

   // One row of the directed table: a request and, where it is obvious, its result.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } vector_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     busy;
   req_type                  req_data  = '0;
   logic                     rsp_strobe;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_HEAP_BASE;
   logic [ADDR_BITS-1:0]     csr_data  = '0;

   // Shadow copy of the allocator state and of its configuration.
   logic [COUNT_BITS-1:0]    shadow_next [FRAME_LIMIT];
   logic [COUNT_BITS-1:0]    shadow_head  = COUNT_BITS'(FRAME_LIMIT);
   logic [COUNT_BITS-1:0]    shadow_free  = '0;
   logic [COUNT_BITS-1:0]    shadow_total = '0;
   bit                       shadow_ready = 1'b0;
   logic [ADDR_BITS-1:0]     heap_base    = '0;
   logic [SIZE_BITS-1:0]     heap_size    = '0;

   rsp_type                  awaited_rsp [$];
   int unsigned              held_frames [$];
   vector_type               directed_rows [$];
   int                       error_count  = 0;
   int                       cycle_count  = 0;

   page_frame_free_list_allocator #(
      .MAX_FRAMES (FRAME_LIMIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Work out the result of one request and advance the shadow state.
   function automatic rsp_type predict_allocator(input req_type req);
      rsp_type              rsp;
      logic [ADDR_BITS-1:0] offset;
      logic [ADDR_BITS-1:0] page;
      int unsigned          frames;
      rsp        = '0;
      rsp.status = STAT_OK;
      offset     = req.free_address - heap_base;
      page       = offset >> FRAME_SHIFT;
      if (req.mode == MODE_INIT) begin
         if (shadow_ready) begin
            rsp.status = STAT_ALREADY;
         end else begin
            frames = 32'(heap_size) >> FRAME_SHIFT;
            if (frames > FRAME_LIMIT) begin
               frames = FRAME_LIMIT;
            end
            for (int i = 0; i < frames; i++) begin
               shadow_next[i] = (i + 1 < frames) ? COUNT_BITS'(i + 1)
                                                 : COUNT_BITS'(FRAME_LIMIT);
            end
            shadow_total = COUNT_BITS'(frames);
            shadow_free  = COUNT_BITS'(frames);
            shadow_head  = (frames > 0) ? '0 : COUNT_BITS'(FRAME_LIMIT);
            shadow_ready = 1'b1;
         end
      end else if (!shadow_ready) begin
         rsp.status = STAT_NOT_INIT;
      end else if (req.mode == MODE_FINAL) begin
         shadow_free  = '0;
         shadow_total = '0;
         shadow_head  = COUNT_BITS'(FRAME_LIMIT);
         shadow_ready = 1'b0;
      end else if (req.mode == MODE_ALLOC) begin
         if (shadow_head >= FRAME_LIMIT) begin
            rsp.status = STAT_EMPTY;
         end else begin
            rsp.frame_address = heap_base + (ADDR_BITS'(shadow_head) << FRAME_SHIFT);
            shadow_head       = shadow_next[shadow_head];
            if (shadow_free > 0) begin
               shadow_free = shadow_free - COUNT_BITS'(1);
            end
         end
      end else begin
         // Alignment is checked before the range of the heap.
         if (req.free_address[FRAME_SHIFT-1:0] != '0) begin
            rsp.status = STAT_MISALIGNED;
         end else if (req.free_address < heap_base || offset[FRAME_SHIFT-1:0] != '0 ||
                      page >= shadow_total || page >= FRAME_LIMIT) begin
            rsp.status = STAT_OUTSIDE;
         end else begin
            shadow_next[page] = shadow_head;
            shadow_head       = COUNT_BITS'(page);
            if (shadow_free < FRAME_LIMIT) begin
               shadow_free = shadow_free + COUNT_BITS'(1);
            end
         end
      end
      rsp.remaining_frames = shadow_free;
      rsp.total_frames     = shadow_total;
      return rsp;
   endfunction

   function automatic vector_type make_row(input mode_type mode, input logic [31:0] addr,
                                           input bit typed, input logic [31:0] frame_addr,
                                           input status_type status, input int remaining,
                                           input int total);
      vector_type row;
      row.req.mode              = mode;
      row.req.free_address      = addr;
      row.typed                 = typed;
      row.rsp.frame_address     = frame_addr;
      row.rsp.status            = status;
      row.rsp.remaining_frames  = COUNT_BITS'(remaining);
      row.rsp.total_frames      = COUNT_BITS'(total);
      return row;
   endfunction

   // Present one request after an idle gap and hold it until it is taken.
   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input req_type req, input int gap, input bit use_typed,
                               input rsp_type typed_rsp, output rsp_type predicted);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_allocator(req);
      awaited_rsp.push_back(use_typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic wait_for_quiet();
      start <= 1'b0;
      do @(negedge clock); while (awaited_rsp.size() != 0 || busy);
   endtask

   // Write both heap registers back to back; only called while idle.
   task automatic write_heap_config(input logic [31:0] base, input logic [22:0] size);
      csr_valid <= 1'b1;
      csr_index <= CSR_HEAP_BASE;
      csr_data  <= base;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      heap_base = base;
      @(negedge clock);
      csr_index <= CSR_HEAP_SIZE;
      csr_data  <= ADDR_BITS'(size);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      heap_size = size;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Compare each result with the oldest outstanding expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with no request outstanding: frame_address %h status %0d",
                   rsp_data.frame_address, rsp_data.status);
            error_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.frame_address !== want.frame_address) begin
               $error("frame_address: expected %h, actual %h",
                      want.frame_address, rsp_data.frame_address);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.remaining_frames !== want.remaining_frames) begin
               $error("remaining_frames: expected %0d, actual %0d",
                      want.remaining_frames, rsp_data.remaining_frames);
               error_count++;
            end
            if (rsp_data.total_frames !== want.total_frames) begin
               $error("total_frames: expected %0d, actual %0d",
                      want.total_frames, rsp_data.total_frames);
               error_count++;
            end
         end
      end
   end

   initial begin
      rsp_type               predicted;
      req_type               req;
      logic [ADDR_BITS-1:0]  addr;
      logic [ADDR_BITS-1:0]  phase_base;
      logic [SIZE_BITS-1:0]  phase_size;
      int                    idle_pct;
      int                    roll;
      int                    gap;
      int                    pick;

      // Four frames at 0x10000: misuse before initialize, draining the list,
      // bad frees, a double free and a re-initialize after finalize.
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0,        1, 0, STAT_NOT_INIT, 0, 0));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_0000, 1, 0, STAT_NOT_INIT, 0, 0));
      directed_rows.push_back(make_row(MODE_FINAL, 32'hFFFF_FFFF, 1, 0, STAT_NOT_INIT, 0, 0));
      directed_rows.push_back(make_row(MODE_INIT,  32'h0,        1, 0, STAT_OK, 4, 4));
      directed_rows.push_back(make_row(MODE_INIT,  32'h0,        1, 0, STAT_ALREADY, 4, 4));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0, 1, 32'h0001_0000, STAT_OK, 3, 4));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0, 1, 32'h0001_1000, STAT_OK, 2, 4));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0, 1, 32'h0001_2000, STAT_OK, 1, 4));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0, 1, 32'h0001_3000, STAT_OK, 0, 4));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0,        1, 0, STAT_EMPTY, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_0001, 1, 0, STAT_MISALIGNED, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'hFFFF_FFFF, 1, 0, STAT_MISALIGNED, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0000_F000, 1, 0, STAT_OUTSIDE, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_4000, 1, 0, STAT_OUTSIDE, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'hFFFF_F000, 1, 0, STAT_OUTSIDE, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0,        1, 0, STAT_OUTSIDE, 0, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_2000, 1, 0, STAT_OK, 1, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_2000, 0, 0, STAT_OK, 0, 0));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_0000, 0, 0, STAT_OK, 0, 0));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0,        0, 0, STAT_OK, 0, 0));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0,        0, 0, STAT_OK, 0, 0));
      directed_rows.push_back(make_row(MODE_ALLOC, 32'h0,        0, 0, STAT_OK, 0, 0));
      directed_rows.push_back(make_row(MODE_FINAL, 32'h0,        1, 0, STAT_OK, 0, 0));
      directed_rows.push_back(make_row(MODE_INIT,  32'hFFFF_FFFF, 1, 0, STAT_OK, 4, 4));
      directed_rows.push_back(make_row(MODE_FREE,  32'h0001_3000, 0, 0, STAT_OK, 0, 0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_heap_config(32'h0001_0000, 23'd16384);
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, 0, directed_rows[i].typed,
                      directed_rows[i].rsp, predicted);
      end

      // Random phases, each setting its heap and its idle percentage.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_quiet();
         case (p)
            0: begin phase_base = 32'h0000_0000; phase_size = 23'd32768;   idle_pct = 0;  end
            1: begin phase_base = 32'hFFFF_F000; phase_size = 23'd16484;   idle_pct = 50; end
            2: begin phase_base = 32'h8000_0000; phase_size = 23'd0;       idle_pct = 24; end
            3: begin phase_base = 32'h0040_0000; phase_size = 23'd4194304; idle_pct = 0;  end
            4: begin phase_base = 32'hFFFF_F000; phase_size = 23'h7F_FFFF; idle_pct = 50; end
            5: begin phase_base = 32'h1234_5000; phase_size = 23'd12288;   idle_pct = 24; end
            6: begin phase_base = 32'h0000_0000; phase_size = 23'd4096;    idle_pct = 0;  end
            default: begin
               phase_base = 32'hABCD_E000; phase_size = 23'd81920; idle_pct = 50;
            end
         endcase
         write_heap_config(phase_base, phase_size);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            addr = $urandom();
            // Each phase opens by finalizing and re-initializing with the new size.
            if (n < 2) begin
               req.mode = (n == 0) ? MODE_FINAL : MODE_INIT;
            end else if (!shadow_ready) begin
               req.mode = (roll < 75) ? MODE_INIT : mode_type'($urandom_range(0, 3));
            end else if (roll < 2) begin
               req.mode = MODE_INIT;
            end else if (roll < 5) begin
               req.mode = MODE_FINAL;
            end else if (roll < 50) begin
               req.mode = MODE_ALLOC;
            end else begin
               req.mode = MODE_FREE;
               if (roll < 85 && shadow_total != 0) begin
                  // Mostly return a frame that is out; sometimes any frame (double free).
                  if (held_frames.size() != 0 && $urandom_range(0, 4) != 0) begin
                     pick = $urandom_range(0, held_frames.size() - 1);
                     addr = heap_base + (held_frames[pick] << FRAME_SHIFT);
                     held_frames.delete(pick);
                  end else begin
                     addr = heap_base +
                            ($urandom_range(0, shadow_total - 1) << FRAME_SHIFT);
                  end
               end else if (roll >= 92) begin
                  case ($urandom_range(0, 2))
                     0: addr = addr & 32'hFFFF_F000;
                     1: addr = heap_base - FRAME_BYTES;
                     default: addr = heap_base + (ADDR_BITS'(shadow_total) << FRAME_SHIFT);
                  endcase
               end
            end
            req.free_address = addr;

            // Now and then hold off until everything outstanding has come back.
            if ($urandom_range(0, 99) == 0) begin
               wait_for_quiet();
            end
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct) gap++;
            send_request(req, gap, 1'b0, '0, predicted);

            if (predicted.status == STAT_OK) begin
               if (req.mode == MODE_ALLOC) begin
                  held_frames.push_back((predicted.frame_address - heap_base) >> FRAME_SHIFT);
               end else if (req.mode != MODE_FREE) begin
                  held_frames.delete();
               end
            end
         end
      end

      wait_for_quiet();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pffl_pkg.sv
rtl/core/pffl_table.sv
rtl/core/pffl_ctrl.sv
rtl/core/page_frame_free_list_allocator.sv
dv/testbench.sv
